FILE: design/drop_detect_report_framer_macros.svh
// assertion macros shared by the drop-detect report framer rtl
// no dependencies; taken in by `include with the bare file name
`ifndef DROP_DETECT_REPORT_FRAMER_MACROS_SVH
`define DROP_DETECT_REPORT_FRAMER_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define DDRF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ddrf assertion failed");

// next-cycle implication, off while reset is asserted
`define DDRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ddrf assertion failed");

`endif

FILE: design/ddrf_pkg.sv
// shared types and constants of the drop-detect report framer
// no dependencies; used by the window, base table, serializer and top-level modules
`default_nettype none

package ddrf_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int THRESH_W = 20;
    localparam int PERIOD_W = 8;
    localparam int NODE_W   = 16;
    localparam int RSSI_W   = 16;
    localparam int ID_W     = 16;
    localparam int KIND_W   = 8;
    localparam int CFG_W    = 20;
    localparam int REG_IDX_W = 2;

    // operation codes
    localparam logic OP_SAMPLE_TICK = 1'b0;
    localparam logic OP_BEACON      = 1'b1;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_DROP_THRESHOLD  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CLEAR_PERIOD    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_NODE_IDENTIFIER = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_CLEARED_RSSI    = 2'd3;

    // register reset values
    localparam logic [THRESH_W-1:0]      DROP_THRESHOLD_RST  = 20'd500;
    localparam logic [PERIOD_W-1:0]      CLEAR_PERIOD_RST    = 8'd35;
    localparam logic [NODE_W-1:0]        NODE_IDENTIFIER_RST = 16'd1;
    localparam logic signed [RSSI_W-1:0] CLEARED_RSSI_RST    = -16'sd100;

    // beacon kind that masks the base id to its low byte
    localparam logic [KIND_W-1:0] KIND_SHORT_ID = 8'h00;
    localparam logic [ID_W-1:0]   SHORT_ID_MASK = 16'h00FF;

    // frame layout
    localparam logic [7:0] FRAME_SYNC     = 8'hFF;
    localparam logic [7:0] FRAME_PROTO    = 8'h01;
    localparam logic [7:0] FRAME_PAD      = 8'h00;
    localparam logic [7:0] EVENT_DROP     = 8'h01;
    localparam int         HDR_LEN        = 12;
    localparam int         ENTRY_LEN      = 4;
    localparam int         CSUM_START     = 3;
    localparam int         LEN_BASE       = 3;
    localparam logic [7:0] FRAME_CNT_RST  = 8'h01;
    localparam logic [7:0] FRAME_CNT_MAX  = 8'hFF;

    typedef struct packed {
        logic                       operation;
        logic [SAMPLE_W-1:0]        sample_value;
        logic [KIND_W-1:0]          beacon_kind;
        logic [ID_W-1:0]            beacon_base_id;
        logic signed [RSSI_W-1:0]   link_rssi;
    } in_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } out_item_t;

    // item moves into the state logic this cycle
    typedef struct packed {
        logic tick;
        logic beacon;
    } go_t;

    // frame serializer status
    typedef struct packed {
        logic busy;
        logic free;
    } ser_status_t;

endpackage

`default_nettype wire

FILE: design/ddrf_stream_if.sv
// valid/ready channel carrying one item per handshake
// payload type is a parameter; item types come from ddrf_pkg
`default_nettype none

interface ddrf_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: design/ddrf_window.sv
// sample window: shift line of the last samples with a running sum
// depends on ddrf_pkg
`default_nettype none

module ddrf_window #(
    parameter int WINDOW_LEN = 6
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic [ddrf_pkg::SAMPLE_W-1:0] sample_value,
    input  wire logic [ddrf_pkg::THRESH_W-1:0] drop_threshold,
    output logic                               drop
);
    localparam int SUM_W = ddrf_pkg::SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int CMP_W = (SUM_W > ddrf_pkg::THRESH_W) ? SUM_W : ddrf_pkg::THRESH_W;

    logic [ddrf_pkg::SAMPLE_W-1:0] taps_reg [WINDOW_LEN];
    logic [SUM_W-1:0]              sum_reg;
    logic [SUM_W-1:0]              sum_next;

    // oldest sample leaves, new one enters
    assign sum_next = sum_reg + SUM_W'(sample_value) - SUM_W'(taps_reg[WINDOW_LEN-1]);
    assign drop     = CMP_W'(sum_next) > CMP_W'(drop_threshold);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                taps_reg[i] <= '0;
            end
            sum_reg <= '0;
        end
        else if (advance)
        begin
            taps_reg[0] <= sample_value;
            for (int i = 1; i < WINDOW_LEN; i++)
            begin
                taps_reg[i] <= taps_reg[i-1];
            end
            sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/ddrf_base_table.sv
// base station table with periodic rssi clear
// depends on ddrf_pkg
`default_nettype none

module ddrf_base_table #(
    parameter int BASE_ENTRIES = 2,
    localparam int CNT_W = $clog2(BASE_ENTRIES + 1)
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire ddrf_pkg::go_t                        go,
    input  wire logic [ddrf_pkg::KIND_W-1:0]          beacon_kind,
    input  wire logic [ddrf_pkg::ID_W-1:0]            beacon_base_id,
    input  wire logic signed [ddrf_pkg::RSSI_W-1:0]   link_rssi,
    input  wire logic [ddrf_pkg::PERIOD_W-1:0]        clear_period,
    input  wire logic signed [ddrf_pkg::RSSI_W-1:0]   cleared_rssi,
    output logic [ddrf_pkg::ID_W-1:0]                 ids [BASE_ENTRIES],
    output logic signed [ddrf_pkg::RSSI_W-1:0]        rssi_next [BASE_ENTRIES],
    output logic [CNT_W-1:0]                          base_count
);
    logic [ddrf_pkg::ID_W-1:0]          ids_reg [BASE_ENTRIES];
    logic [ddrf_pkg::ID_W-1:0]          ids_next [BASE_ENTRIES];
    logic signed [ddrf_pkg::RSSI_W-1:0] rssi_reg [BASE_ENTRIES];
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic [ddrf_pkg::PERIOD_W-1:0]      clr_cnt_reg;
    logic [ddrf_pkg::PERIOD_W-1:0]      clr_cnt_next;
    logic [ddrf_pkg::PERIOD_W-1:0]      clr_cnt_inc;
    logic [ddrf_pkg::ID_W-1:0]          beacon_id;
    logic                               found;

    assign beacon_id = (beacon_kind == ddrf_pkg::KIND_SHORT_ID)
                       ? (beacon_base_id & ddrf_pkg::SHORT_ID_MASK) : beacon_base_id;
    assign clr_cnt_inc = clr_cnt_reg + 1'b1;

    always_comb
    begin
        ids_next     = ids_reg;
        rssi_next    = rssi_reg;
        count_next   = count_reg;
        clr_cnt_next = clr_cnt_reg;
        found        = 1'b0;
        if (go.tick)
        begin
            clr_cnt_next = clr_cnt_inc;
            if (clr_cnt_inc >= clear_period)
            begin
                clr_cnt_next = '0;
                for (int k = 0; k < BASE_ENTRIES; k++)
                begin
                    rssi_next[k] = cleared_rssi;
                end
            end
        end
        else if (go.beacon)
        begin
            // first known entry with this id takes the rssi
            for (int k = 0; k < BASE_ENTRIES; k++)
            begin
                if (!found && (CNT_W'(k) < count_reg) && (ids_reg[k] == beacon_id))
                begin
                    found        = 1'b1;
                    rssi_next[k] = link_rssi;
                end
            end
            // new id only while there is room
            if (!found && (count_reg < CNT_W'(BASE_ENTRIES)))
            begin
                for (int k = 0; k < BASE_ENTRIES; k++)
                begin
                    if (CNT_W'(k) == count_reg)
                    begin
                        ids_next[k]  = beacon_id;
                        rssi_next[k] = link_rssi;
                    end
                end
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < BASE_ENTRIES; k++)
            begin
                ids_reg[k]  <= '0;
                rssi_reg[k] <= '0;
            end
            count_reg   <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            ids_reg     <= ids_next;
            rssi_reg    <= rssi_next;
            count_reg   <= count_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign ids        = ids_reg;
    assign base_count = count_reg;

endmodule

`default_nettype wire

FILE: design/ddrf_serializer.sv
// frame serializer: byte shift line, running checksum, output channel
// depends on ddrf_pkg and ddrf_stream_if
`default_nettype none

module ddrf_serializer #(
    parameter int BASE_ENTRIES = 2,
    localparam int FRAME_LEN = ddrf_pkg::HDR_LEN + ddrf_pkg::ENTRY_LEN * BASE_ENTRIES + 1,
    localparam int BODY_LEN  = FRAME_LEN - 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire logic [7:0]       frame_body [BODY_LEN],
    output ddrf_pkg::ser_status_t status,
    ddrf_stream_if.source         out_ch
);
    localparam int IDX_W = $clog2(FRAME_LEN);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] CSUM_IDX0 = IDX_W'(ddrf_pkg::CSUM_START);

    logic [7:0]       body_reg [BODY_LEN];
    logic [IDX_W-1:0] idx_reg;
    logic [7:0]       acc_reg;
    logic             busy_reg;
    logic             is_last;
    logic             take;

    assign is_last = (idx_reg == LAST_IDX);
    assign take    = busy_reg && out_ch.ready;

    assign status.busy = busy_reg;
    assign status.free = !busy_reg || (take && is_last);

    assign out_ch.valid              = busy_reg;
    assign out_ch.payload.frame_byte = is_last ? 8'(8'h00 - acc_reg) : body_reg[0];
    assign out_ch.payload.frame_last = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (take)
        begin
            busy_reg <= !is_last;
            idx_reg  <= is_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            body_reg <= frame_body;
            acc_reg  <= '0;
        end
        else if (take)
        begin
            for (int i = 0; i < BODY_LEN - 1; i++)
            begin
                body_reg[i] <= body_reg[i+1];
            end
            if (idx_reg >= CSUM_IDX0 && !is_last)
            begin
                acc_reg <= acc_reg + body_reg[0];
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/drop_detect_report_framer.sv
// Drop-detect report framer. An item is either a sample tick or a base beacon, taken on
// in_ch; the item is registered and then handled, so items enter one per cycle unless
// a drop tick is held back. A tick whose six-sample window sum (the last WINDOW_LEN
// samples) exceeds drop_threshold produces a report frame of 13 + 4*BASE_ENTRIES bytes
// (21 by default) on out_ch, one byte per cycle while out_ch is ready, frame_last on
// the closing checksum byte. The frame is built from the input register and loaded
// into the serializer, which then offers the first byte.
// Only one frame is held at a time: a drop tick waits in the input register until the
// frame in flight hands over its last byte, so a reporting tick is not handled before
// the frame ahead of it is through the byte-wide output port; beacons and quiet ticks
// keep one per cycle. Configuration writes on cfg_wr_en/cfg_index/cfg_data take effect
// at the next edge and must only be made while the block is idle.
// depends on ddrf_pkg, ddrf_stream_if, ddrf_window, ddrf_base_table, ddrf_serializer
// and the assertion macros header
`default_nettype none
`include "drop_detect_report_framer_macros.svh"

module drop_detect_report_framer #(
    parameter int WINDOW_LEN   = 6,
    parameter int BASE_ENTRIES = 2
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    ddrf_stream_if.sink                         in_ch,
    ddrf_stream_if.source                       out_ch,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ddrf_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [ddrf_pkg::CFG_W-1:0]     cfg_data
);
    localparam int CNT_W     = $clog2(BASE_ENTRIES + 1);
    localparam int FRAME_LEN = ddrf_pkg::HDR_LEN + ddrf_pkg::ENTRY_LEN * BASE_ENTRIES + 1;
    localparam int BODY_LEN  = FRAME_LEN - 1;

    // configuration registers
    logic [ddrf_pkg::THRESH_W-1:0]      drop_threshold_reg;
    logic [ddrf_pkg::PERIOD_W-1:0]      clear_period_reg;
    logic [ddrf_pkg::NODE_W-1:0]        node_identifier_reg;
    logic signed [ddrf_pkg::RSSI_W-1:0] cleared_rssi_reg;

    // input register
    logic                 in_valid_reg;
    ddrf_pkg::in_item_t   in_item_reg;
    logic                 proc_go;
    ddrf_pkg::go_t        go;

    // state and frame build
    logic                               drop;
    logic                               frame_load;
    logic [7:0]                         frame_cnt_reg;
    logic [7:0]                         frame_cnt_next;
    logic [ddrf_pkg::ID_W-1:0]          ids [BASE_ENTRIES];
    logic signed [ddrf_pkg::RSSI_W-1:0] rssi_next [BASE_ENTRIES];
    logic [CNT_W-1:0]                   base_count;
    logic [15:0]                        frame_len_field;
    logic [7:0]                         frame_body [BODY_LEN];
    ddrf_pkg::ser_status_t              ser_stat;

    // check terms
    logic                               held_stall;
    logic                               last_handed;

    // ---------------------------------------------------------------- config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_threshold_reg  <= ddrf_pkg::DROP_THRESHOLD_RST;
            clear_period_reg    <= ddrf_pkg::CLEAR_PERIOD_RST;
            node_identifier_reg <= ddrf_pkg::NODE_IDENTIFIER_RST;
            cleared_rssi_reg    <= ddrf_pkg::CLEARED_RSSI_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ddrf_pkg::REG_DROP_THRESHOLD:  drop_threshold_reg  <= cfg_data;
                ddrf_pkg::REG_CLEAR_PERIOD:    clear_period_reg    <= cfg_data[7:0];
                ddrf_pkg::REG_NODE_IDENTIFIER: node_identifier_reg <= cfg_data[15:0];
                ddrf_pkg::REG_CLEARED_RSSI:    cleared_rssi_reg    <= $signed(cfg_data[15:0]);
            endcase
        end
    end

    // ---------------------------------------------------------------- input stage
    // the held item moves on unless it is a drop tick and a frame is still going out
    assign proc_go = in_valid_reg
                     && ((in_item_reg.operation == ddrf_pkg::OP_BEACON) || !drop
                         || ser_stat.free);
    assign go.tick   = proc_go && (in_item_reg.operation == ddrf_pkg::OP_SAMPLE_TICK);
    assign go.beacon = proc_go && (in_item_reg.operation == ddrf_pkg::OP_BEACON);
    assign in_ch.ready = !in_valid_reg || proc_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_item_reg <= in_ch.payload;
        end
    end

    // ---------------------------------------------------------------- window and table
    ddrf_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (go.tick),
        .sample_value   (in_item_reg.sample_value),
        .drop_threshold (drop_threshold_reg),
        .drop           (drop)
    );

    ddrf_base_table #(
        .BASE_ENTRIES (BASE_ENTRIES)
    ) u_table (
        .clk            (clk),
        .rst_n          (rst_n),
        .go             (go),
        .beacon_kind    (in_item_reg.beacon_kind),
        .beacon_base_id (in_item_reg.beacon_base_id),
        .link_rssi      (in_item_reg.link_rssi),
        .clear_period   (clear_period_reg),
        .cleared_rssi   (cleared_rssi_reg),
        .ids            (ids),
        .rssi_next      (rssi_next),
        .base_count     (base_count)
    );

    // ---------------------------------------------------------------- frame build
    assign frame_load = go.tick && drop;

    // counter byte advances per frame, 255 wraps to 1
    assign frame_cnt_next = (frame_cnt_reg >= ddrf_pkg::FRAME_CNT_MAX)
                            ? ddrf_pkg::FRAME_CNT_RST : frame_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_cnt_reg <= ddrf_pkg::FRAME_CNT_RST;
        end
        else if (frame_load)
        begin
            frame_cnt_reg <= frame_cnt_next;
        end
    end

    assign frame_len_field = 16'(base_count) * 16'(ddrf_pkg::ENTRY_LEN)
                             + 16'(ddrf_pkg::LEN_BASE);

    // header then table entries; rssi values already reflect a clear on this tick
    always_comb
    begin
        frame_body[0]  = ddrf_pkg::FRAME_SYNC;
        frame_body[1]  = ddrf_pkg::FRAME_SYNC;
        frame_body[2]  = ddrf_pkg::FRAME_SYNC;
        frame_body[3]  = ddrf_pkg::FRAME_PROTO;
        frame_body[4]  = frame_cnt_reg;
        frame_body[5]  = ddrf_pkg::FRAME_PAD;
        frame_body[6]  = frame_len_field[15:8];
        frame_body[7]  = frame_len_field[7:0];
        frame_body[8]  = node_identifier_reg[15:8];
        frame_body[9]  = node_identifier_reg[7:0];
        frame_body[10] = ddrf_pkg::EVENT_DROP;
        frame_body[11] = ddrf_pkg::FRAME_PAD;
        for (int k = 0; k < BASE_ENTRIES; k++)
        begin
            frame_body[ddrf_pkg::HDR_LEN + ddrf_pkg::ENTRY_LEN*k]     = ids[k][15:8];
            frame_body[ddrf_pkg::HDR_LEN + ddrf_pkg::ENTRY_LEN*k + 1] = ids[k][7:0];
            frame_body[ddrf_pkg::HDR_LEN + ddrf_pkg::ENTRY_LEN*k + 2] = rssi_next[k][15:8];
            frame_body[ddrf_pkg::HDR_LEN + ddrf_pkg::ENTRY_LEN*k + 3] = rssi_next[k][7:0];
        end
    end

    // ---------------------------------------------------------------- output
    ddrf_serializer #(
        .BASE_ENTRIES (BASE_ENTRIES)
    ) u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (frame_load),
        .frame_body (frame_body),
        .status     (ser_stat),
        .out_ch     (out_ch)
    );

    // ---------------------------------------------------------------- checks
    assign held_stall  = in_valid_reg && !proc_go;
    assign last_handed = out_ch.valid && out_ch.ready && out_ch.payload.frame_last
                         && !frame_load;

    // frame counter skips zero on wrap
    `DDRF_ASSERT_IMPLY(a_frame_cnt_nonzero, clk, rst_n, 1'b1, frame_cnt_reg != 8'h00)
    // table never grows past its size
    `DDRF_ASSERT_IMPLY(a_table_bounded, clk, rst_n, 1'b1, base_count <= CNT_W'(BASE_ENTRIES))
    // a held drop tick keeps its item until the serializer frees up
    `DDRF_ASSERT_NEXT(a_stall_holds, clk, rst_n, held_stall, in_valid_reg && $stable(in_item_reg))
    // after the checksum byte the port idles unless a new frame was loaded
    `DDRF_ASSERT_NEXT(a_frame_end, clk, rst_n, last_handed, !out_ch.valid)

endmodule

`default_nettype wire
